/* hw/rtl/efe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and constants for the escaped frame encoder.
// ----------------------------------------------------------------------------
package efe_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] REG_FRAME_END      = 2'd0;
  localparam logic [1:0] REG_ESCAPE         = 2'd1;
  localparam logic [1:0] REG_ESCAPED_END    = 2'd2;
  localparam logic [1:0] REG_ESCAPED_ESCAPE = 2'd3;

  localparam logic [7:0] RST_FRAME_END      = 8'd192;
  localparam logic [7:0] RST_ESCAPE         = 8'd219;
  localparam logic [7:0] RST_ESCAPED_END    = 8'd220;
  localparam logic [7:0] RST_ESCAPED_ESCAPE = 8'd221;

  localparam logic [7:0] CHECK_BASE = 8'hff;

  typedef struct packed {
    logic [7:0] frame_end;
    logic [7:0] escape;
    logic [7:0] escaped_end;
    logic [7:0] escaped_escape;
  } codes_t;

  // One item expanded into at most three line bytes
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;    // 0 means no bytes
    logic            finish;   // last byte closes the frame
    logic [7:0]      sum_next;
  } expand_t;

endpackage
`default_nettype wire

/* hw/rtl/efe_expand.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efe_expand
// Expands one transaction into its line bytes and the next checksum.
// ----------------------------------------------------------------------------
module efe_expand import efe_pkg::*; (
  input  wire logic [1:0] op,
  input  wire logic [7:0] value,
  input  wire logic [7:0] sum,
  input  wire codes_t     codes,
  output expand_t         result
);

  logic [7:0] esc_byte;
  logic [7:0] esc_first;
  logic [7:0] esc_second;
  logic       esc_pair;
  logic [7:0] check;

  assign check    = CHECK_BASE - sum;
  assign esc_byte = (op == OP_FINISH) ? check : value;

  // Frame-end match wins when both reserved codes are equal
  always_comb begin
    esc_pair   = 1'b0;
    esc_first  = esc_byte;
    esc_second = esc_byte;
    if (esc_byte == codes.frame_end) begin
      esc_pair   = 1'b1;
      esc_first  = codes.escape;
      esc_second = codes.escaped_end;
    end else if (esc_byte == codes.escape) begin
      esc_pair   = 1'b1;
      esc_first  = codes.escape;
      esc_second = codes.escaped_escape;
    end
  end

  always_comb begin
    result.bytes    = '0;
    result.count    = 2'd0;
    result.finish   = 1'b0;
    result.sum_next = sum;
    case (op_t'(op))
      OP_START: begin
        result.bytes[0] = codes.frame_end;
        result.bytes[1] = value;
        result.count    = 2'd2;
        result.sum_next = value;
      end
      OP_DATA: begin
        result.bytes[0] = esc_first;
        result.bytes[1] = esc_second;
        result.count    = esc_pair ? 2'd2 : 2'd1;
        result.sum_next = sum + value;
      end
      OP_FINISH: begin
        result.bytes[0] = esc_first;
        result.bytes[1] = esc_pair ? esc_second : codes.frame_end;
        result.bytes[2] = codes.frame_end;
        result.count    = esc_pair ? 2'd3 : 2'd2;
        result.finish   = 1'b1;
        result.sum_next = check + check;
      end
      default: begin
        result.count = 2'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/escaped_frame_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_encoder
// Frame builder with byte escaping and a byte-sum check byte, streaming
// the encoded frame one byte per output transaction.
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+------------------------
//  in       | in_valid, in_ready, op, value        | start / data / finish
//  out      | out_valid, out_ready, out_byte,      | one line byte
//           | run_last, frame_done                 |
//  cfg      | cfg_we, cfg_index, cfg_data          | reserved code registers
//
// A start, data or finish transaction expands into one to three line bytes
// (one for a plain data byte, two for start or an escaped byte, up to three
// for finish); the result buffer emits them in order, one per cycle while
// out_ready is high. The next item is taken in the same cycle that the
// last byte of the current one leaves, so no bubble appears.
// Reset clears the checksum, the buffer and the code registers to defaults.
// A stall on out_ready holds the current byte and back-pressures in_ready.
// An unused op code is taken and produces nothing.
// ----------------------------------------------------------------------------
module escaped_frame_encoder import efe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] value,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            frame_done,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  codes_t          codes;
  logic [7:0]      running_sum;
  expand_t         expanded;

  // result buffer
  logic            buf_valid;
  logic [2:0][7:0] slots;
  logic [1:0]      count;
  logic [1:0]      idx;
  logic            finish;

  logic            take;
  logic            last_take;
  logic            accept;
  logic            is_last;

  efe_expand u_expand (
    .op     (op),
    .value  (value),
    .sum    (running_sum),
    .codes  (codes),
    .result (expanded)
  );

  // Handshake: take a new transaction when the buffer is empty or empties this cycle
  assign is_last   = (idx == (count - 2'd1));
  assign take      = buf_valid && out_ready;
  assign last_take = take && is_last;
  assign in_ready  = !buf_valid || last_take;
  assign accept    = in_valid && in_ready;

  // Code registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.frame_end      <= RST_FRAME_END;
      codes.escape         <= RST_ESCAPE;
      codes.escaped_end    <= RST_ESCAPED_END;
      codes.escaped_escape <= RST_ESCAPED_ESCAPE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_END:      codes.frame_end      <= cfg_data;
        REG_ESCAPE:         codes.escape         <= cfg_data;
        REG_ESCAPED_END:    codes.escaped_end    <= cfg_data;
        REG_ESCAPED_ESCAPE: codes.escaped_escape <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Checksum advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
    end else if (accept) begin
      running_sum <= expanded.sum_next;
    end
  end

  // Buffer control: load, advance, or drop after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (accept && (expanded.count != 2'd0)) begin
      buf_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (last_take) begin
      buf_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      idx       <= idx + 2'd1;
    end
  end

  // Payload of the buffer needs no reset
  always_ff @(posedge clk) begin
    if (accept && (expanded.count != 2'd0)) begin
      slots  <= expanded.bytes;
      count  <= expanded.count;
      finish <= expanded.finish;
    end
  end

  // Select the byte under the read pointer
  always_comb begin
    case (idx)
      2'd0:    out_byte = slots[0];
      2'd1:    out_byte = slots[1];
      2'd2:    out_byte = slots[2];
      default: out_byte = slots[0];
    endcase
  end

  assign out_valid  = buf_valid;
  assign run_last   = is_last;
  assign frame_done = is_last && finish;

endmodule
`default_nettype wire

/* verif/efe_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efe_tb_pkg
// Line byte predictor and scoreboard for the escaped frame encoder bench.
// ----------------------------------------------------------------------------
package efe_tb_pkg;
  import efe_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       done;
  } line_byte_t;

  class frame_scoreboard;
    codes_t      codes;
    logic [7:0]  checksum;
    line_byte_t  bytes_due[$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned items_taken;
    int unsigned frames_closed;

    function new();
      codes = '{frame_end: RST_FRAME_END, escape: RST_ESCAPE,
                escaped_end: RST_ESCAPED_END, escaped_escape: RST_ESCAPED_ESCAPE};
      checksum      = '0;
      mismatches    = 0;
      bytes_checked = 0;
      items_taken   = 0;
      frames_closed = 0;
    endfunction

    function void set_code(input logic [1:0] idx, input logic [7:0] data);
      case (idx)
        REG_FRAME_END:      codes.frame_end      = data;
        REG_ESCAPE:         codes.escape         = data;
        REG_ESCAPED_END:    codes.escaped_end    = data;
        REG_ESCAPED_ESCAPE: codes.escaped_escape = data;
        default: ;
      endcase
    endfunction

    function void push_byte(input logic [7:0] b, input logic last, input logic done);
      line_byte_t lb;
      lb.data = b;
      lb.last = last;
      lb.done = done;
      bytes_due.push_back(lb);
    endfunction

    // Add to the checksum, then send as is or as an escaped pair
    function void push_escaped(input logic [7:0] b, input logic mark_last);
      checksum = checksum + b;
      if (b == codes.frame_end) begin
        push_byte(codes.escape, 1'b0, 1'b0);
        push_byte(codes.escaped_end, mark_last, 1'b0);
      end else if (b == codes.escape) begin
        push_byte(codes.escape, 1'b0, 1'b0);
        push_byte(codes.escaped_escape, mark_last, 1'b0);
      end else begin
        push_byte(b, mark_last, 1'b0);
      end
    endfunction

    function void note_item(input op_t o, input logic [7:0] v);
      logic [7:0] check;
      case (o)
        OP_START: begin
          push_byte(codes.frame_end, 1'b0, 1'b0);
          push_byte(v, 1'b1, 1'b0);
          checksum = v;
          items_taken++;
        end
        OP_DATA: begin
          push_escaped(v, 1'b1);
          items_taken++;
        end
        OP_FINISH: begin
          check    = CHECK_BASE - checksum;
          checksum = check;
          push_escaped(check, 1'b0);
          push_byte(codes.frame_end, 1'b1, 1'b1);
          items_taken++;
          frames_closed++;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(input logic [7:0] b, input logic last, input logic done);
      line_byte_t want;
      bytes_checked++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected line byte %02h last=%0b done=%0b", $time, b, last, done);
        return;
      end
      want = bytes_due.pop_front();
      if (b !== want.data || last !== want.last || done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: line byte mismatch: expected %02h last=%0b done=%0b, got %02h last=%0b done=%0b",
                   $time, want.data, want.last, want.done, b, last, done);
      end
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escaped frame encoder: drives start, data and
// finish transactions under random idling on both channels, reprograms the
// reserved codes between phases and checks every line byte in order.
// ----------------------------------------------------------------------------
module tb_top;
  import efe_pkg::*;
  import efe_tb_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  op_t        op        = OP_NONE;
  logic [7:0] value     = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_FRAME_END;
  logic [7:0] cfg_data  = 8'h00;

  // no idling on either side once set; used for the closing stretch
  bit          quiet = 1'b0;
  int unsigned code_settings = 1;
  frame_scoreboard sb;

  escaped_frame_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_done (frame_done),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge. Note the input transaction
  // first, so that a byte leaving in the same edge always finds its
  // expectation already queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(op, value);
      if (out_valid && out_ready)
        sb.check_byte(out_byte, run_last, frame_done);
    end
  end

  // Receiver: at random, stall for a burst of random length, otherwise accept freely
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 12);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Hard stop, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[escaped_frame_encoder] ERROR");
    $finish;
  end

  // Offer one input transaction and hold it until taken. Valid stays high
  // into the next item unless an idle burst is drawn.
  task automatic send_item(input op_t o, input logic [7:0] v);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op       = o;
    value    = v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every expected byte, then idle for the extra cycles
  // below; an unused op code is taken with nothing to emit and never sits in the block.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_code(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.set_code(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_codes(input logic [7:0] fe, input logic [7:0] esc,
                            input logic [7:0] ee, input logic [7:0] eesc);
    drain();
    write_code(REG_FRAME_END, fe);
    write_code(REG_ESCAPE, esc);
    write_code(REG_ESCAPED_END, ee);
    write_code(REG_ESCAPED_ESCAPE, eesc);
    code_settings++;
  endtask

  // Bias payload towards the reserved codes so escaping is hit often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return sb.codes.frame_end;
      1:       return sb.codes.escape;
      2:       return sb.codes.escaped_end;
      3:       return sb.codes.escaped_escape;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames with random content, the rest stray items:
  // a lone start, data or finish outside a frame, and unused op codes.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned n;
    op_t         o;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        o = op_t'($urandom_range(0, 3));
        send_item(o, 8'($urandom_range(0, 255)));
        if (o != OP_NONE)
          sent++;
      end else begin
        send_item(OP_START, pick_byte());
        n = $urandom_range(0, 6);
        repeat (n) send_item(OP_DATA, pick_byte());
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
        sent += n + 2;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset codes: command equal to frame-end is sent raw,
    // payload extremes and every reserved value, an unused op code, data and
    // finish outside a frame, and sums that make the check byte a reserved
    // code (0x3f gives frame-end, 0x24 gives escape).
    send_item(OP_START, 8'hc0);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hff);
    send_item(OP_DATA, 8'hc0);
    send_item(OP_DATA, 8'hdb);
    send_item(OP_DATA, 8'hdc);
    send_item(OP_DATA, 8'hdd);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_NONE, 8'ha5);
    send_item(OP_DATA, 8'h5a);
    send_item(OP_FINISH, 8'hff);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_START, 8'h3f);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_START, 8'h24);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_START, 8'hff);
    send_item(OP_NONE, 8'h00);
    send_item(OP_DATA, 8'h01);
    send_item(OP_FINISH, 8'h00);

    // Extreme codes
    load_codes(8'h00, 8'hff, 8'hff, 8'h00);
    run_random(20);

    // Frame-end and escape equal: a matching byte is escaped as a frame-end
    load_codes(8'h7e, 8'h7e, 8'h5e, 8'h5d);
    send_item(OP_START, 8'h7e);
    send_item(OP_DATA, 8'h7e);
    send_item(OP_DATA, 8'h5e);
    send_item(OP_FINISH, 8'h00);
    run_random(15);

    // Random codes, with a pause mid-phase until the line has emptied
    load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(10);
    drain();
    run_random(10);

    // Extremes the other way round
    load_codes(8'hff, 8'h00, 8'h00, 8'hff);
    run_random(20);

    // Back to the usual codes; hold both sides busy for the closing stretch
    load_codes(RST_FRAME_END, RST_ESCAPE, RST_ESCAPED_END, RST_ESCAPED_ESCAPE);
    quiet = 1'b1;
    run_random(20);

    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d input transactions, %0d frames closed, %0d code settings;",
             sb.items_taken, sb.frames_closed, code_settings);
    $display("checked %0d line bytes, %0d mismatches.", sb.bytes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[escaped_frame_encoder] OK");
    end else begin
      $display("[escaped_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/efe_pkg.sv
hw/rtl/efe_expand.sv
hw/rtl/escaped_frame_encoder.sv
verif/efe_tb_pkg.sv
verif/tb_top.sv
